### design/dfr_pkg.sv
// Shared types and constants of the serial frame deframer.
package dfr_pkg;

	// Default and largest supported frame buffer size in bytes.
	localparam int FRAME_BYTES_DEF = 64;
	localparam int FRAME_BYTES_MAX = 1024;

	// Payload length fits below the largest buffer size.
	localparam int LEN_W = $clog2(FRAME_BYTES_MAX);

	// Configuration register indexes.
	localparam logic CFG_FRAME_HEAD  = 1'b0;
	localparam logic CFG_LINK_ENABLE = 1'b1;

	// Input item kinds.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Result event kinds.
	localparam logic EV_DATA      = 1'b0;
	localparam logic EV_LINK_LOST = 1'b1;

	typedef struct packed {
		logic [15:0] frame_head;
		logic        link_enable;
	} dfr_cfg_t;

	// Work handed from the front to the back.
	typedef struct packed {
		logic             kind;
		logic [15:0]      ptype;
		logic [LEN_W-1:0] plen;
		logic             joined;
	} dfr_cmd_t;

	typedef struct packed {
		logic frame_done;
	} dfr_back_stat_t;

	typedef struct packed {
		logic        event_kind;
		logic [15:0] packet_type;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
		logic        link_up;
		logic        just_connected;
	} dfr_result_t;

endpackage

### design/dfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/dfr_front.sv
// Front part: accepts input beats, assembles and checks frames, issues commands.
module dfr_front #(
	parameter int FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dfr_pkg::dfr_cfg_t              cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_opcode,
	input  logic [7:0]                     in_byte,
	input  dfr_pkg::dfr_back_stat_t        stat,
	input  logic                           cmd_full,
	output logic                           cmd_push,
	output dfr_pkg::dfr_cmd_t              cmd,
	output logic                           ram_we,
	output logic [$clog2(FRAME_BYTES)-1:0] ram_waddr,
	output logic [7:0]                     ram_wdata
);
	import dfr_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] FILL_LAST = AW'(FRAME_BYTES - 1);
	localparam logic [15:0]   LEN_LIMIT = 16'(FRAME_BYTES - 5);

	logic [AW-1:0] fill_q, fill_d, fill_next;
	logic [15:0]   head_q, type_q, len_q, len_now;
	logic [7:0]    len_lo_q, xor_q, xor_new;
	logic          link_q, link_d, lock_q;
	logic          accept, active, is_byte, overflow, have4;
	logic          head_bad, len_bad, complete;

	assign in_ready  = !lock_q && !cmd_full;
	assign accept    = in_valid && in_ready;
	assign active    = accept && cfg.link_enable;
	assign is_byte   = active && (in_opcode == OP_BYTE);
	assign overflow  = (fill_q == FILL_LAST);
	assign fill_next = fill_q + AW'(1);
	assign have4     = (fill_q >= AW'(3));
	assign xor_new   = (fill_q == AW'(4)) ? in_byte : (xor_q ^ in_byte);
	assign len_now   = (fill_q == AW'(3)) ? {in_byte, len_lo_q} : len_q;
	assign head_bad  = (head_q != cfg.frame_head);
	assign len_bad   = (len_now >= LEN_LIMIT) || (len_now < 16'd2);
	assign complete  = (16'(fill_next) == (len_now + 16'd5));

	assign ram_we    = is_byte && !overflow;
	assign ram_waddr = fill_q;
	assign ram_wdata = in_byte;

	always_comb begin
		fill_d   = fill_q;
		link_d   = link_q;
		cmd_push = 1'b0;
		cmd      = '0;
		if (active && (in_opcode == OP_TIMEOUT)) begin
			link_d   = 1'b0;
			cmd_push = 1'b1;
			cmd.kind = EV_LINK_LOST;
		end else if (is_byte) begin
			if (overflow) begin
				fill_d = '0;
			end else if (!have4) begin
				fill_d = fill_next;
			end else if (head_bad || len_bad) begin
				fill_d = '0;
			end else if (!complete) begin
				fill_d = fill_next;
			end else begin
				fill_d = '0;
				if (xor_new == 8'd0) begin
					link_d     = 1'b1;
					cmd_push   = 1'b1;
					cmd.kind   = EV_DATA;
					cmd.ptype  = type_q;
					cmd.plen   = LEN_W'(len_now - 16'd2);
					cmd.joined = !link_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			link_q <= 1'b0;
			lock_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			link_q <= link_d;
			if (cmd_push && (cmd.kind == EV_DATA)) begin
				lock_q <= 1'b1;
			end else if (stat.frame_done) begin
				lock_q <= 1'b0;
			end
		end
	end

	// Header fields and the running check are captured as the bytes arrive.
	always_ff @(posedge clk) begin
		if (ram_we) begin
			case (fill_q)
				AW'(0): head_q[7:0]  <= in_byte;
				AW'(1): head_q[15:8] <= in_byte;
				AW'(2): len_lo_q     <= in_byte;
				AW'(3): len_q        <= {in_byte, len_lo_q};
				AW'(4): type_q[7:0]  <= in_byte;
				AW'(5): type_q[15:8] <= in_byte;
				default: ;
			endcase
			xor_q <= xor_new;
		end
	end

endmodule

### design/dfr_cmd_fifo.sv
// Two-entry command queue between the front and the back.
module dfr_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfr_pkg::dfr_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output dfr_pkg::dfr_cmd_t head_cmd
);
	import dfr_pkg::*;

	dfr_cmd_t   entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push && !full) - 2'(pop && head_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### design/dfr_back.sv
// Back part: turns queued commands into result beats, reading payload from the RAM.
module dfr_back #(
	parameter int FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  dfr_pkg::dfr_cmd_t              cmd,
	output logic                           cmd_pop,
	output dfr_pkg::dfr_back_stat_t        stat,
	output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr,
	input  logic [7:0]                     ram_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dfr_pkg::dfr_result_t           res
);
	import dfr_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [AW-1:0]    rd_addr_q;
	logic [LEN_W-1:0] rem_q;
	logic             out_valid_q;
	dfr_result_t      res_q;
	logic             slot_free, single, load_out;

	assign slot_free = !out_valid_q || out_ready;
	// Link-lost events and empty frames need no payload read.
	assign single    = (cmd.kind == EV_LINK_LOST) || (cmd.plen == '0);

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign ram_raddr = rd_addr_q;

	// The output register is loaded with a new beat whenever it is free and a beat is ready.
	always_comb begin
		cmd_pop  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				load_out = cmd_valid && single && slot_free;
				cmd_pop  = cmd_valid && single && slot_free;
			end
			ST_EMIT: begin
				load_out = slot_free;
				cmd_pop  = slot_free && (rem_q == LEN_W'(1));
			end
			default: begin
				cmd_pop  = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	assign stat.frame_done = cmd_pop && (cmd.kind == EV_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && !single) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= (rem_q == LEN_W'(1)) ? ST_IDLE : ST_WAIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_addr_q <= AW'(6);
				rem_q     <= cmd.plen;
				if (cmd_valid && single && slot_free) begin
					res_q.event_kind     <= cmd.kind;
					res_q.packet_type    <= cmd.ptype;
					res_q.payload_byte   <= 8'd0;
					res_q.byte_valid     <= 1'b0;
					res_q.last           <= 1'b1;
					res_q.link_up        <= (cmd.kind == EV_DATA);
					res_q.just_connected <= cmd.joined;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					res_q.event_kind     <= EV_DATA;
					res_q.packet_type    <= cmd.ptype;
					res_q.payload_byte   <= ram_rdata;
					res_q.byte_valid     <= 1'b1;
					res_q.last           <= (rem_q == LEN_W'(1));
					res_q.link_up        <= 1'b1;
					res_q.just_connected <= cmd.joined;
					rd_addr_q            <= rd_addr_q + AW'(1);
					rem_q                <= rem_q - LEN_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

### design/serial_frame_deframer_xor_check.sv
// Serial frame deframer: one input beat per received byte or link timeout; a frame
// (head, length, type, payload, XOR check byte) that passes its checks leaves as one
// output beat per payload byte, closed by tlast, or as one closing beat if it is empty.
// Input beats are taken every cycle except while the command queue is full and from the
// moment the front hands a good frame to the back until the back has read the last
// payload byte, because payload and new bytes share one frame buffer RAM. For each
// payload byte the back goes through a wait state (RAM address) and an emit state
// (registered read data); a link timeout or empty frame needs no RAM read. A two-entry
// command queue lets timeout events and the front keep moving while the output side is
// stalled. Frames are dropped silently when the head differs from frame_head, when the
// length is below 2 or at least FRAME_BYTES-5, when the buffer would overflow, or when
// the XOR over type, payload and check byte is nonzero. With link_enable low every input
// beat is consumed and ignored. The frame buffer needs no clearing after reset.
module serial_frame_deframer_xor_check #(
	parameter int FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port: index 0 frame_head, index 1 link_enable.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] opcode
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] packet_type, [23:16] payload_byte, [24] byte_valid, [25] link_up,
	// [26] just_connected, [31:27] zero
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tuser,  // [0] event_kind
	output logic        m_axis_tlast   // last
);
	import dfr_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);

	dfr_cfg_t       cfg_q;
	dfr_cmd_t       push_cmd, head_cmd;
	dfr_back_stat_t back_stat;
	dfr_result_t    res;
	logic           cmd_push, cmd_full, cmd_pop, cmd_valid;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_head  <= 16'd0;
			cfg_q.link_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_HEAD:  cfg_q.frame_head  <= cfg_data;
				CFG_LINK_ENABLE: cfg_q.link_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front assembles bytes into the frame buffer and checks each frame.
	dfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.stat      (back_stat),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (push_cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// Frame buffer holding the bytes of the frame being received.
	dfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dfr_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (push_cmd),
		.full       (cmd_full),
		.pop        (cmd_pop),
		.head_valid (cmd_valid),
		.head_cmd   (head_cmd)
	);

	// The back turns each command into result beats behind an output register.
	dfr_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.stat      (back_stat),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {5'd0, res.just_connected, res.link_up, res.byte_valid,
		res.payload_byte, res.packet_type};
	assign m_axis_tuser = res.event_kind;
	assign m_axis_tlast = res.last;

	// The front must never hand a command to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

	// A link-lost beat is a single closing beat with the link down.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == EV_LINK_LOST)) |->
		(m_axis_tlast && !m_axis_tdata[25] && !m_axis_tdata[26]))
		else $error("malformed link-lost beat");

	// A beat that reports a fresh connection must show the link up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[26]) |-> m_axis_tdata[25])
		else $error("just_connected without link_up");

	// A beat without payload data carries a zero payload byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[24]) |-> (m_axis_tdata[23:16] == 8'd0))
		else $error("payload byte set on an empty beat");

endmodule
